// ----- hdl/lru_recency_list_assert.svh -----
// Assertion macros shared by the recency list RTL.
// Each macro expects clk and rst_n in scope and checks only outside reset.
`ifndef LRU_RECENCY_LIST_ASSERT_SVH
`define LRU_RECENCY_LIST_ASSERT_SVH

// Same-cycle implication.
`define LRU_RL_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lru_recency_list: same-cycle check failed");

// Next-cycle implication.
`define LRU_RL_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lru_recency_list: next-cycle check failed");

`endif

// ----- hdl/lru_rl_pkg.sv -----
package lru_rl_pkg;

  // Field widths of the request and result items
  localparam int ENTRY_W = 4;
  localparam int ENTRY_SPAN = 1 << ENTRY_W;

  // Default pool size
  localparam int LRU_NUM_FRAMES = 16;

  // Operation codes
  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_TOUCH  = 2'd1,
    FN_REMOVE = 2'd2,
    FN_EVICT  = 2'd3
  } func_t;

  typedef struct packed {
    func_t              func;
    logic [ENTRY_W-1:0] entry_index;
  } req_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] victim_entry;
    logic               victim_valid;
    logic               status;
  } res_t;

endpackage

// ----- hdl/lru_recency_list.sv -----
// Channel  Direction  Payload
// in_      slave      tuser: func; tdata: entry_index
// out_     master     tuser: victim_valid, status; tdata: victim_entry
//
// One item per cycle sustained while out_tready holds; an accepted item passes the request and result registers.
// The list update sits between the request register and the result register.
// rst_n (synchronous) empties the list; link entries need no clearing.
// A stalled result holds the request register, and in_tready drops only then.
module lru_recency_list #(
  parameter int NUM_FRAMES = lru_rl_pkg::LRU_NUM_FRAMES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [3:0] entry_index, [7:4] zero
  input  logic [1:0] in_tuser,   // [1:0] func
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [3:0] victim_entry, [7:4] zero
  output logic [1:0] out_tuser   // [0] victim_valid, [1] status
);
  import lru_rl_pkg::*;

  logic in_valid_r;
  req_t req_r;
  logic out_valid_r;
  res_t res_r;
  res_t core_res;
  logic advance;

  // Output register free or draining this cycle
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;

  // Capture the request item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      req_r.func        <= func_t'(in_tuser);
      req_r.entry_index <= in_tdata[ENTRY_W-1:0];
    end
  end

  lru_rl_core #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid_r && advance),
    .req       (req_r),
    .res       (core_res)
  );

  // Register the result item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, res_r.victim_entry};
  assign out_tuser  = {res_r.status, res_r.victim_valid};

endmodule

// ----- hdl/lru_rl_core.sv -----
module lru_rl_core #(
  parameter int NUM_FRAMES = lru_rl_pkg::LRU_NUM_FRAMES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  input  lru_rl_pkg::req_t  req,
  output lru_rl_pkg::res_t  res
);
  import lru_rl_pkg::*;

  // Only frames reachable through the 4-bit index ever get links
  localparam int LINK_DEPTH = (NUM_FRAMES < ENTRY_SPAN) ? NUM_FRAMES : ENTRY_SPAN;
  localparam int LIDX_W = $clog2(LINK_DEPTH);
  localparam int PTR_W = $clog2(NUM_FRAMES + 1);
  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(NUM_FRAMES);

  logic [PTR_W-1:0]  next_r [LINK_DEPTH];
  logic [PTR_W-1:0]  prev_r [LINK_DEPTH];
  logic [PTR_W-1:0]  next_nxt [LINK_DEPTH];
  logic [PTR_W-1:0]  prev_nxt [LINK_DEPTH];
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [LINK_DEPTH-1:0] member_r, member_nxt;

  logic [LIDX_W-1:0] a_idx;
  logic [PTR_W-1:0]  f_ptr;
  logic [PTR_W-1:0]  nx, pv, app_tail;
  logic              in_range, is_member, nx_frame, pv_frame;
  logic              do_unlink, do_append, set_mem, clr_mem;

  // Decode the request against the current list
  always_comb begin
    a_idx     = (req.func == FN_EVICT) ? head_r[LIDX_W-1:0] : req.entry_index[LIDX_W-1:0];
    f_ptr     = PTR_W'(req.entry_index);
    in_range  = (int'(req.entry_index) < NUM_FRAMES);
    is_member = in_range && member_r[a_idx];
    nx        = next_r[a_idx];
    pv        = prev_r[a_idx];
    nx_frame  = (nx != NULL_PTR);
    pv_frame  = (pv != NULL_PTR);

    do_unlink = 1'b0;
    do_append = 1'b0;
    set_mem   = 1'b0;
    clr_mem   = 1'b0;
    res       = '0;

    unique case (req.func)
      FN_INSERT: begin
        if (!in_range || is_member) begin
          res.status = 1'b1;
        end else begin
          do_append = 1'b1;
          set_mem   = 1'b1;
        end
      end
      FN_TOUCH: begin
        if (!is_member) begin
          res.status = 1'b1;
        end else if (tail_r != f_ptr) begin
          do_unlink = 1'b1;
          do_append = 1'b1;
        end
      end
      FN_REMOVE: begin
        if (!is_member) begin
          res.status = 1'b1;
        end else begin
          do_unlink = 1'b1;
          clr_mem   = 1'b1;
        end
      end
      FN_EVICT: begin
        if (head_r == NULL_PTR) begin
          res.status = 1'b1;
        end else begin
          do_unlink          = 1'b1;
          clr_mem            = 1'b1;
          res.victim_valid   = 1'b1;
          res.victim_entry   = ENTRY_W'(head_r);
        end
      end
      default: res.status = 1'b1;
    endcase
  end

  // Build the updated links: unlink first, then append at the tail
  always_comb begin
    next_nxt   = next_r;
    prev_nxt   = prev_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    member_nxt = member_r;

    if (do_unlink) begin
      if (nx_frame) begin
        prev_nxt[nx[LIDX_W-1:0]] = pv;
      end else begin
        tail_nxt = pv;
      end
      if (pv_frame) begin
        next_nxt[pv[LIDX_W-1:0]] = nx;
      end else begin
        head_nxt = nx;
      end
    end

    app_tail = (do_unlink && !nx_frame) ? pv : tail_r;

    if (do_append) begin
      next_nxt[a_idx] = NULL_PTR;
      prev_nxt[a_idx] = app_tail;
      if (app_tail != NULL_PTR) begin
        next_nxt[app_tail[LIDX_W-1:0]] = f_ptr;
      end else begin
        head_nxt = f_ptr;
      end
      tail_nxt = f_ptr;
    end

    if (set_mem) begin
      member_nxt[a_idx] = 1'b1;
    end
    if (clr_mem) begin
      member_nxt[a_idx] = 1'b0;
    end
  end

  // Hold list pointers and membership
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= NULL_PTR;
      tail_r   <= NULL_PTR;
      member_r <= '0;
    end else if (req_valid) begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      member_r <= member_nxt;
    end
  end

  // Hold link entries; a frame's links are written before they are read
  always_ff @(posedge clk) begin
    if (req_valid) begin
      next_r <= next_nxt;
      prev_r <= prev_nxt;
    end
  end

`include "lru_recency_list_assert.svh"

  `LRU_RL_ASSERT_IMPL(a_ends_agree, 1'b1, (head_r == NULL_PTR) == (tail_r == NULL_PTR))
  `LRU_RL_ASSERT_IMPL(a_empty_no_members, 1'b1, (head_r == NULL_PTR) == (member_r == '0))
  `LRU_RL_ASSERT_IMPL(a_victim_was_member, req_valid && res.victim_valid, member_r[a_idx])
  `LRU_RL_ASSERT_NEXT(a_insert_at_tail, req_valid && req.func == FN_INSERT && !res.status, tail_r == $past(f_ptr))

endmodule
